>>> sv/bhls_pkg.sv
// Shared types and constants for the header length scanner.
package bhls_pkg;

	// Expected magic after reset: "BAM\1", first byte in the low bits
	localparam logic [31:0] MAGIC_RESET  = 32'h014D_4142;
	localparam logic [7:0]  NEWLINE_BYTE = 8'h0A;

	// Result status codes
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_BAD_MAGIC = 1'b1;

	// Header bytes taken before a magic check completes
	localparam logic [31:0] MAGIC_BYTES = 32'd4;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// One classified header byte
	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic       newline;
	} byte_item_t;

endpackage

>>> sv/bhls_front.sv
// Front end: takes input bytes, tags newlines and start marks, feeds the queue.
module bhls_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          data_byte,
	input  logic                start_header,
	output logic                push_valid,
	output bhls_pkg::byte_item_t push_item,
	input  logic                push_ready
);
	import bhls_pkg::*;

	logic       valid_s1;
	byte_item_t item_s1;
	logic       load;

	// Stage register frees up when empty or when the queue takes it
	assign in_stall   = valid_s1 && !push_ready;
	assign load       = in_valid && !in_stall;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	// Classify the byte on the way in
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.data    <= data_byte;
			item_s1.start   <= start_header;
			item_s1.newline <= (data_byte == NEWLINE_BYTE);
		end
	end

endmodule

>>> sv/bhls_queue.sv
// Short request queue between the front and the back.
module bhls_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	input  bhls_pkg::byte_item_t push_item,
	output logic                 push_ready,
	output logic                 pop_valid,
	output bhls_pkg::byte_item_t pop_item,
	input  logic                 pop_ready
);
	import bhls_pkg::*;

	byte_item_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QPTR_W:0]       count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != QUEUE_DEPTH[QPTR_W:0]);
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> sv/bhls_back.sv
// Back end: header field parser, byte and newline counters, result register.
module bhls_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [31:0]          cfg_wdata,
	input  logic                 pop_valid,
	input  bhls_pkg::byte_item_t pop_item,
	output logic                 pop_ready,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 status,
	output logic [31:0]          header_length,
	output logic [31:0]          line_count
);
	import bhls_pkg::*;

	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_LTEXT,
		PH_TEXT,
		PH_NREF,
		PH_LNAME,
		PH_NAME,
		PH_LREF
	} phase_t;

	logic [31:0] magic_q;
	phase_t      phase_q, ph, ph_n;
	logic [1:0]  bif_q, bif, bif_n;
	logic [23:0] acc_q, acc, acc_n, acc_shift;
	logic [31:0] rem_q, rem, rem_n;
	logic [31:0] refs_q, refs, refs_n;
	logic [31:0] tot_q, tot, tot_n;
	logic [31:0] nl_q, nl, nl_n;
	logic        fin_q, fin, fin_n;
	logic        field_done;
	logic [31:0] field_val;
	logic        emit;
	logic        emit_status;
	logic        out_valid_q;
	logic        take;

	assign out_valid = out_valid_q;
	assign pop_ready = !out_valid_q || !out_stall;
	assign take      = pop_valid && pop_ready;

	// Magic register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= MAGIC_RESET;
		end else if (cfg_we) begin
			magic_q <= cfg_wdata;
		end
	end

	// Start mark clears the scan state before the byte is used
	always_comb begin
		ph   = pop_item.start ? PH_MAGIC : phase_q;
		bif  = pop_item.start ? 2'd0 : bif_q;
		acc  = pop_item.start ? 24'd0 : acc_q;
		rem  = pop_item.start ? 32'd0 : rem_q;
		refs = pop_item.start ? 32'd0 : refs_q;
		tot  = pop_item.start ? 32'd0 : tot_q;
		nl   = pop_item.start ? 32'd0 : nl_q;
		fin  = pop_item.start ? 1'b0 : fin_q;
	end

	// Little-endian field assembly
	always_comb begin
		field_done = (bif == 2'd3);
		field_val  = {pop_item.data, acc};
		case (bif)
			2'd0:    acc_shift = {acc[23:8], pop_item.data};
			2'd1:    acc_shift = {acc[23:16], pop_item.data, acc[7:0]};
			2'd2:    acc_shift = {pop_item.data, acc[15:0]};
			default: acc_shift = acc;
		endcase
	end

	// Field walk for one byte
	always_comb begin
		ph_n        = ph;
		bif_n       = bif;
		acc_n       = acc;
		rem_n       = rem;
		refs_n      = refs;
		tot_n       = tot;
		nl_n        = nl;
		fin_n       = fin;
		emit        = 1'b0;
		emit_status = STATUS_OK;
		if (!fin) begin
			tot_n = tot + 32'd1;
			if (ph == PH_MAGIC || ph == PH_LTEXT || ph == PH_NREF ||
			    ph == PH_LNAME || ph == PH_LREF) begin
				bif_n = field_done ? 2'd0 : bif + 2'd1;
				acc_n = field_done ? 24'd0 : acc_shift;
			end
			unique case (ph)
				PH_MAGIC: begin
					if (field_done) begin
						if (field_val != magic_q) begin
							emit        = 1'b1;
							emit_status = STATUS_BAD_MAGIC;
						end else begin
							ph_n = PH_LTEXT;
						end
					end
				end
				PH_LTEXT: begin
					if (field_done) begin
						rem_n = field_val;
						ph_n  = (field_val != 32'd0) ? PH_TEXT : PH_NREF;
					end
				end
				PH_TEXT: begin
					if (pop_item.newline) begin
						nl_n = nl + 32'd1;
					end
					rem_n = rem - 32'd1;
					if (rem == 32'd1) begin
						ph_n = PH_NREF;
					end
				end
				PH_NREF: begin
					if (field_done) begin
						refs_n = field_val;
						if (field_val == 32'd0) begin
							emit = 1'b1;
						end else begin
							ph_n = PH_LNAME;
						end
					end
				end
				PH_LNAME: begin
					if (field_done) begin
						rem_n = field_val;
						ph_n  = (field_val != 32'd0) ? PH_NAME : PH_LREF;
					end
				end
				PH_NAME: begin
					rem_n = rem - 32'd1;
					if (rem == 32'd1) begin
						ph_n = PH_LREF;
					end
				end
				PH_LREF: begin
					if (field_done) begin
						refs_n = refs - 32'd1;
						if (refs == 32'd1) begin
							emit = 1'b1;
						end else begin
							ph_n = PH_LNAME;
						end
					end
				end
				default: begin
					ph_n = ph;
				end
			endcase
			if (emit) begin
				fin_n = 1'b1;
			end
		end
	end

	// Scan state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAGIC;
			bif_q       <= '0;
			acc_q       <= '0;
			rem_q       <= '0;
			refs_q      <= '0;
			tot_q       <= '0;
			nl_q        <= '0;
			fin_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= ph_n;
				bif_q   <= bif_n;
				acc_q   <= acc_n;
				rem_q   <= rem_n;
				refs_q  <= refs_n;
				tot_q   <= tot_n;
				nl_q    <= nl_n;
				fin_q   <= fin_n;
			end
			if (take && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take && emit) begin
			status        <= emit_status;
			header_length <= tot_n;
			line_count    <= nl_n;
		end
	end

endmodule

>>> sv/bam_header_length_scanner.sv
// Top level of the header length scanner: front, queue and back joined.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  in       | in_valid / in_stall  | data_byte, start_header
//  out      | out_valid / out_stall| status, header_length, line_count
//  cfg      | cfg_we               | cfg_wdata (magic word)
//
// Unless a held result is stalled, one byte per cycle is sustained and the
// back parser handles one byte each cycle. A result passes the front stage
// and queue into the result register. Reset clears all scan state and loads
// the magic default. A stall on a held result stops the back; the queue then
// fills, and in_stall rises only once it and the front stage are full.
module bam_header_length_scanner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        start_header,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [31:0] header_length,
	output logic [31:0] line_count
);
	import bhls_pkg::*;

	logic       q_push_valid;
	byte_item_t q_push_item;
	logic       q_push_ready;
	logic       q_pop_valid;
	byte_item_t q_pop_item;
	logic       q_pop_ready;

	bhls_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.start_header (start_header),
		.push_valid   (q_push_valid),
		.push_item    (q_push_item),
		.push_ready   (q_push_ready)
	);

	bhls_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_item  (q_push_item),
		.push_ready (q_push_ready),
		.pop_valid  (q_pop_valid),
		.pop_item   (q_pop_item),
		.pop_ready  (q_pop_ready)
	);

	bhls_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.pop_valid     (q_pop_valid),
		.pop_item      (q_pop_item),
		.pop_ready     (q_pop_ready),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.header_length (header_length),
		.line_count    (line_count)
	);

`ifndef NO_ASSERTIONS
	// A magic mismatch always reports four bytes and no lines
	a_bad_magic_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == STATUS_BAD_MAGIC |-> header_length == MAGIC_BYTES &&
		line_count == 32'd0)
		else $error("bad magic result with wrong length or line count");

	// Input stalls only while the front stage holds a request the queue refuses
	a_stall_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> !q_push_ready && q_push_valid)
		else $error("input stalled with room in the queue");

	// Back never takes from the queue while a result waits under stall
	a_pop_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !q_pop_ready)
		else $error("back consumed a byte while result held");

	// Queue cannot report both full and empty
	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(!q_push_ready && !q_pop_valid))
		else $error("queue full and empty at once");
`endif

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the header length scanner: byte stream in, checked results out.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bhls_pkg::*;

	localparam int FIELD_LEN    = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef enum logic [2:0] {
		SCAN_MAGIC,
		SCAN_LTEXT,
		SCAN_TEXT,
		SCAN_NREF,
		SCAN_LNAME,
		SCAN_NAME,
		SCAN_LREF
	} scan_phase_t;

	typedef struct packed {
		logic        status;
		logic [31:0] header_length;
		logic [31:0] line_count;
	} scan_result_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_we       = 1'b0;
	logic [31:0] cfg_wdata    = '0;
	logic        in_valid     = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte    = '0;
	logic        start_header = 1'b0;
	logic        out_valid;
	logic        out_stall    = 1'b0;
	logic        status;
	logic [31:0] header_length;
	logic [31:0] line_count;

	bam_header_length_scanner dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.start_header (start_header),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.header_length(header_length),
		.line_count   (line_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Scanner state as the testbench tracks it
	scan_phase_t  hdr_phase      = SCAN_MAGIC;
	logic [1:0]   hdr_pos        = '0;
	logic [31:0]  hdr_acc        = '0;
	logic [31:0]  hdr_left       = '0;
	logic [31:0]  hdr_refs       = '0;
	logic [31:0]  hdr_total      = '0;
	logic [31:0]  hdr_lines      = '0;
	logic         hdr_done       = 1'b0;
	logic [31:0]  magic_expected = MAGIC_RESET;

	scan_result_t pending_results[$];
	logic [7:0]   hdr_bytes[$];
	int           bytes_scanned  = 0;
	int           fail_count     = 0;
	bit           no_idle        = 1'b0;
	int           hold_request   = 0;
	int           hold_left      = 0;
	int           stall_left     = 0;

	task automatic clear_header();
		hdr_phase = SCAN_MAGIC;
		hdr_pos   = '0;
		hdr_acc   = '0;
		hdr_left  = '0;
		hdr_refs  = '0;
		hdr_total = '0;
		hdr_lines = '0;
		hdr_done  = 1'b0;
	endtask

	// Little-endian field assembly; true on the fourth byte
	function automatic logic take_field(input logic [7:0] b, output logic [31:0] word);
		hdr_acc = hdr_acc | (32'(b) << (8 * hdr_pos));
		word = hdr_acc;
		if (hdr_pos == 2'(FIELD_LEN - 1)) begin
			hdr_acc = '0;
			hdr_pos = '0;
			return 1'b1;
		end
		hdr_pos = hdr_pos + 2'd1;
		return 1'b0;
	endfunction

	task automatic post_result(input logic code);
		pending_results.push_back('{status: code, header_length: hdr_total,
			line_count: hdr_lines});
		hdr_done = 1'b1;
	endtask

	// Advance the tracked scan by one accepted byte
	task automatic track_header_byte(input logic [7:0] b, input logic s);
		logic [31:0] word;
		if (s)
			clear_header();
		if (hdr_done)
			return;
		hdr_total = hdr_total + 32'd1;
		bytes_scanned++;
		case (hdr_phase)
			SCAN_MAGIC: begin
				if (take_field(b, word)) begin
					if (word != magic_expected)
						post_result(STATUS_BAD_MAGIC);
					else
						hdr_phase = SCAN_LTEXT;
				end
			end
			SCAN_LTEXT: begin
				if (take_field(b, word)) begin
					hdr_left  = word;
					hdr_phase = (word != 0) ? SCAN_TEXT : SCAN_NREF;
				end
			end
			SCAN_TEXT: begin
				if (b == NEWLINE_BYTE)
					hdr_lines = hdr_lines + 32'd1;
				hdr_left = hdr_left - 32'd1;
				if (hdr_left == 0)
					hdr_phase = SCAN_NREF;
			end
			SCAN_NREF: begin
				if (take_field(b, word)) begin
					hdr_refs = word;
					if (word == 0)
						post_result(STATUS_OK);
					else
						hdr_phase = SCAN_LNAME;
				end
			end
			SCAN_LNAME: begin
				if (take_field(b, word)) begin
					hdr_left  = word;
					hdr_phase = (word != 0) ? SCAN_NAME : SCAN_LREF;
				end
			end
			SCAN_NAME: begin
				hdr_left = hdr_left - 32'd1;
				if (hdr_left == 0)
					hdr_phase = SCAN_LREF;
			end
			SCAN_LREF: begin
				if (take_field(b, word)) begin
					hdr_refs = hdr_refs - 32'd1;
					if (hdr_refs == 0)
						post_result(STATUS_OK);
					else
						hdr_phase = SCAN_LNAME;
				end
			end
			default: ;
		endcase
	endtask

	// Idle lengths: mostly short, now and then long
	function automatic int gap_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int pick_gap();
		if (no_idle || $urandom_range(0, 1) == 0)
			return 0;
		return gap_length();
	endfunction

	// One request on the input channel, tracked once accepted
	task automatic send_byte(input logic [7:0] b, input logic s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		data_byte    <= b;
		start_header <= s;
		do begin
			@(posedge clk);
		end while (in_stall);
		track_header_byte(b, s);
	endtask

	task automatic add_word(input logic [31:0] w);
		for (int i = 0; i < FIELD_LEN; i++)
			hdr_bytes.push_back(w[8*i +: 8]);
	endtask

	task automatic build_header(input logic [31:0] magic, input int text_len,
			input int nl_pct, input int n_refs, input int max_name);
		int name_len;
		hdr_bytes.delete();
		add_word(magic);
		add_word(text_len);
		for (int i = 0; i < text_len; i++)
			hdr_bytes.push_back(($urandom_range(0, 99) < nl_pct) ? NEWLINE_BYTE :
				8'($urandom_range(0, 255)));
		add_word(n_refs);
		for (int r = 0; r < n_refs; r++) begin
			name_len = $urandom_range(0, max_name);
			add_word(name_len);
			for (int i = 0; i < name_len; i++)
				hdr_bytes.push_back(8'($urandom_range(0, 255)));
			add_word($urandom);
		end
	endtask

	// Send the first count bytes of the built header
	task automatic send_bytes(input logic first_start, input int count);
		for (int i = 0; i < count && i < hdr_bytes.size(); i++)
			send_byte(hdr_bytes[i], (i == 0) ? first_start : 1'b0);
	endtask

	// Wait for every result, then let the pipeline empty
	task automatic wait_idle();
		int n;
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		n = 0;
		while (n < DRAIN_CYCLES) begin
			@(posedge clk);
			if (!out_stall)
				n++;
		end
	endtask

	task automatic write_magic(input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		magic_expected = value;
	endtask

	// Receiver: random stalls, or a long hold when one is requested
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!no_idle && $urandom_range(0, 99) < 25) begin
			stall_left = gap_length() - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d, header_length %0d, line_count %0d",
					status, header_length, line_count);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (header_length !== want.header_length) begin
					$error("header_length: expected %0d, got %0d",
						want.header_length, header_length);
					fail_count++;
				end
				if (line_count !== want.line_count) begin
					$error("line_count: expected %0d, got %0d",
						want.line_count, line_count);
					fail_count++;
				end
			end
		end
	end

	// Run limit
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("bam_header_length_scanner: mismatch");
		$finish;
	end

	// A header taken right after reset without a start mark
	task automatic test_no_start_after_reset();
		build_header(magic_expected, 5, 40, 1, 3);
		send_bytes(1'b0, hdr_bytes.size());
	endtask

	task automatic test_bad_magic();
		build_header(magic_expected ^ 32'h0100_0000, 2, 0, 0, 0);
		send_bytes(1'b1, hdr_bytes.size());
	endtask

	// Bytes after a result are ignored until the next start mark
	task automatic test_bytes_after_result();
		repeat (6) send_byte(8'($urandom_range(0, 255)), 1'b0);
		send_byte(NEWLINE_BYTE, 1'b0);
	endtask

	task automatic test_zero_lengths();
		build_header(magic_expected, 0, 0, 0, 0);
		send_bytes(1'b1, hdr_bytes.size());
	endtask

	// Several references, including an empty name
	task automatic test_references();
		hdr_bytes.delete();
		add_word(magic_expected);
		add_word(32'd1);
		hdr_bytes.push_back(NEWLINE_BYTE);
		add_word(32'd3);
		add_word(32'd0);
		add_word(32'h0000_1000);
		add_word(32'd1);
		hdr_bytes.push_back(8'h41);
		add_word(32'd7);
		add_word(32'd3);
		hdr_bytes.push_back(8'h63);
		hdr_bytes.push_back(NEWLINE_BYTE);
		hdr_bytes.push_back(8'h72);
		add_word(32'hFFFF_FFFF);
		send_bytes(1'b1, hdr_bytes.size());
	endtask

	// A start mark in the middle of a header begins a new one
	task automatic test_restart_mid_header();
		build_header(magic_expected, 6, 50, 2, 2);
		send_bytes(1'b1, 10);
		build_header(magic_expected, 3, 50, 1, 2);
		send_bytes(1'b1, 2);
		build_header(magic_expected, 3, 50, 1, 2);
		send_bytes(1'b1, hdr_bytes.size());
	endtask

	// Extreme byte values and lengths; endless headers get cut off by a restart
	task automatic test_field_extremes();
		hdr_bytes.delete();
		add_word(magic_expected);
		add_word(32'd4);
		hdr_bytes.push_back(8'h00);
		hdr_bytes.push_back(8'hFF);
		hdr_bytes.push_back(NEWLINE_BYTE);
		hdr_bytes.push_back(NEWLINE_BYTE);
		add_word(32'd1);
		add_word(32'd0);
		add_word(32'hFFFF_FFFF);
		send_bytes(1'b1, hdr_bytes.size());
		hdr_bytes.delete();
		add_word(magic_expected);
		add_word(32'hFFFF_FFFF);
		hdr_bytes.push_back(NEWLINE_BYTE);
		hdr_bytes.push_back(8'hFF);
		send_bytes(1'b1, hdr_bytes.size());
		hdr_bytes.delete();
		add_word(magic_expected);
		add_word(32'd0);
		add_word(32'hFFFF_FFFF);
		add_word(32'd0);
		add_word(32'd0);
		send_bytes(1'b1, hdr_bytes.size());
	endtask

	task automatic test_magic_settings();
		wait_idle();
		write_magic(32'h0000_0000);
		build_header(32'h0000_0000, 2, 50, 1, 2);
		send_bytes(1'b1, hdr_bytes.size());
		build_header(32'h0000_0080, 0, 0, 0, 0);
		send_bytes(1'b1, hdr_bytes.size());
		wait_idle();
		write_magic(32'hFFFF_FFFF);
		build_header(32'hFFFF_FFFF, 1, 100, 0, 0);
		send_bytes(1'b1, hdr_bytes.size());
		build_header(32'h7FFF_FFFF, 0, 0, 0, 0);
		send_bytes(1'b1, hdr_bytes.size());
		wait_idle();
		write_magic(MAGIC_RESET);
	endtask

	// Long receiver hold while the sender keeps offering bytes
	task automatic test_backpressure();
		no_idle = 1'b1;
		hold_request = 400;
		repeat (40) begin
			build_header(magic_expected, 0, 0, 0, 0);
			send_bytes(1'b1, hdr_bytes.size());
		end
		no_idle = 1'b0;
	endtask

	task automatic test_random();
		int target;
		int r;
		logic [31:0] magic;
		target = bytes_scanned + 1200;
		while (bytes_scanned < target) begin
			if ($urandom_range(0, 19) == 0)
				no_idle = !no_idle;
			r = $urandom_range(0, 99);
			if (r < 4) begin
				wait_idle();
				case ($urandom_range(0, 3))
					0: magic = 32'h0000_0000;
					1: magic = 32'hFFFF_FFFF;
					2: magic = MAGIC_RESET;
					default: magic = $urandom;
				endcase
				write_magic(magic);
			end else if (r < 84) begin
				magic = magic_expected;
				if ($urandom_range(0, 9) == 0)
					magic = magic ^ (32'd1 << $urandom_range(0, 31));
				build_header(magic,
					($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) :
						$urandom_range(0, 40),
					$urandom_range(0, 50), $urandom_range(0, 3), 4);
				// Some headers are cut short and left behind
				if (r < 72)
					send_bytes(1'b1, hdr_bytes.size());
				else
					send_bytes(1'b1, $urandom_range(1, hdr_bytes.size() - 1));
			end else if (r < 94) begin
				repeat ($urandom_range(1, 8))
					send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
			end else begin
				repeat ($urandom_range(1, 5))
					send_byte(8'($urandom_range(0, 255)), 1'b0);
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_start_after_reset();
		test_bad_magic();
		test_bytes_after_result();
		test_zero_lengths();
		test_references();
		test_restart_mid_header();
		test_field_extremes();
		test_magic_settings();
		test_backpressure();
		test_random();
		wait_idle();
		if (fail_count == 0 && pending_results.size() == 0)
			$display("bam_header_length_scanner: match");
		else
			$display("bam_header_length_scanner: mismatch");
		$finish;
	end

endmodule

>>> sim.f
sv/bhls_pkg.sv
sv/bhls_front.sv
sv/bhls_queue.sv
sv/bhls_back.sv
sv/bam_header_length_scanner.sv
test/tb_top.sv
